### hdl/tlbl_pkg.sv
// ----------------------------------------------------------------------------
// tlbl_pkg
// shared widths, operation codes and item types of the set associative tlb
// ----------------------------------------------------------------------------
`default_nettype none

package tlbl_pkg;

   localparam int VA_W         = 48;
   localparam int PA_W         = 48;
   localparam int FRAME_W      = 36;
   localparam int OP_W         = 2;
   localparam int RANK_FIELD_W = 3;

   // set count is a power of two
   localparam int DEF_SET_COUNT        = 16;
   localparam int DEF_NUM_WAYS         = 4;
   localparam int DEF_PAGE_OFFSET_BITS = 12;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [OP_W-1:0] OP_CLEAR     = 2'd0;
   localparam logic [OP_W-1:0] OP_PEEK      = 2'd1;
   localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE      = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [VA_W-1:0]    virtual_address;
      logic [FRAME_W-1:0] walk_frame;
      logic               walk_fault;
   } req_type;

   typedef struct packed {
      logic [PA_W-1:0]         physical_address;
      logic                    hit;
      logic                    fault;
      logic [RANK_FIELD_W-1:0] lru_rank;
   } rsp_type;

   // decoded item handed from the front to the back
   typedef struct packed {
      logic [OP_W-1:0]    kind;
      logic [VA_W-1:0]    vpn;
      logic [VA_W-1:0]    offset;
      logic [FRAME_W-1:0] walk_frame;
      logic               walk_fault;
   } cmd_type;

endpackage

`default_nettype wire

### hdl/tlbl_front.sv
// ----------------------------------------------------------------------------
// tlbl_front
// accepts request items, splits the virtual address and queues decoded items
// ----------------------------------------------------------------------------
`default_nettype none

module tlbl_front #(
   parameter int PAGE_OFFSET_BITS = tlbl_pkg::DEF_PAGE_OFFSET_BITS
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   output logic              full,
   input  tlbl_pkg::req_type req_item,
   output logic              cmd_valid,
   output tlbl_pkg::cmd_type cmd_item,
   input  wire               cmd_pop
);
   import tlbl_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

   cmd_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             decoded;
   logic                accept;
   logic                take;
   logic [VA_W-1:0]     off_mask;

   // split the address into page number and offset
   always_comb begin
      off_mask           = (VA_W'(1) << PAGE_OFFSET_BITS) - VA_W'(1);
      decoded.kind       = req_item.operation;
      decoded.vpn        = req_item.virtual_address >> PAGE_OFFSET_BITS;
      decoded.offset     = req_item.virtual_address & off_mask;
      decoded.walk_frame = req_item.walk_frame;
      decoded.walk_fault = req_item.walk_fault;
   end

   assign full      = (count_ff == CNT_FULL);
   assign accept    = push && !full;
   assign cmd_valid = (count_ff != '0);
   assign take      = cmd_pop && cmd_valid;
   assign cmd_item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (accept && !take) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (take && !accept) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

### hdl/tlbl_back.sv
// ----------------------------------------------------------------------------
// tlbl_back
// set table with lru ranks: reads a set row, compares all ways, updates the
// row and holds the result item until it is popped
// ----------------------------------------------------------------------------
`default_nettype none

module tlbl_back #(
   parameter int SET_COUNT        = tlbl_pkg::DEF_SET_COUNT,
   parameter int NUM_WAYS         = tlbl_pkg::DEF_NUM_WAYS,
   parameter int PAGE_OFFSET_BITS = tlbl_pkg::DEF_PAGE_OFFSET_BITS
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               cmd_valid,
   input  tlbl_pkg::cmd_type cmd_item,
   output logic              cmd_pop,
   output logic              empty,
   input  wire               pop,
   output tlbl_pkg::rsp_type rsp_item
);
   import tlbl_pkg::*;

   localparam int SET_SHIFT = $clog2(SET_COUNT);
   localparam int SET_W     = (SET_SHIFT > 0) ? SET_SHIFT : 1;
   localparam int TAG_W     = VA_W - PAGE_OFFSET_BITS - SET_SHIFT;
   localparam int WAY_W     = $clog2(NUM_WAYS);
   localparam int RANK_W    = WAY_W;
   localparam logic [RANK_W-1:0] RANK_MAX   = RANK_W'(NUM_WAYS - 1);
   localparam logic [RANK_W:0]   LIMIT_FILL = (RANK_W + 1)'(NUM_WAYS);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic [NUM_WAYS-1:0][TAG_W-1:0]   tag_mem   [SET_COUNT];
   logic [NUM_WAYS-1:0][FRAME_W-1:0] frame_mem [SET_COUNT];
   logic [NUM_WAYS-1:0][RANK_W-1:0]  rank_mem  [SET_COUNT];

   logic [NUM_WAYS-1:0][TAG_W-1:0]   tag_rd_ff,   tag_row_in;
   logic [NUM_WAYS-1:0][FRAME_W-1:0] frame_rd_ff, frame_row_in;
   logic [NUM_WAYS-1:0][RANK_W-1:0]  rank_rd_ff,  rank_row_in;

   logic [SET_COUNT-1:0][NUM_WAYS-1:0] valid_ff, valid_in;
   logic                              state_ff, state_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   rsp_type                           rsp_ff, rsp_in;
   cmd_type                           cmd_ff;

   logic                              take;
   logic                              commit;
   logic                              wr_en;
   logic [SET_W-1:0]                  rd_set;
   logic [SET_W-1:0]                  cur_set;
   logic [TAG_W-1:0]                  cur_tag;
   logic [PAGE_OFFSET_BITS-1:0]       cur_off;
   logic [NUM_WAYS-1:0]               valid_row;
   logic [NUM_WAYS-1:0]               match;
   logic [NUM_WAYS-1:0][RANK_W-1:0]   rank_cur;
   logic                              hit_found;
   logic                              free_found;
   logic [WAY_W-1:0]                  hit_way;
   logic [WAY_W-1:0]                  free_way;
   logic [WAY_W-1:0]                  old_way;
   logic [RANK_W-1:0]                 old_rank;
   logic [WAY_W-1:0]                  victim;
   logic [WAY_W-1:0]                  target;
   logic [RANK_W:0]                   limit;
   logic                              is_xlate;
   logic                              do_touch;
   logic                              do_fill;

   // set is the low page number bits
   function automatic logic [SET_W-1:0] set_of(input logic [VA_W-1:0] vpn);
      set_of = (SET_SHIFT > 0) ? SET_W'(vpn) : '0;
   endfunction

   assign take    = (state_ff == ST_IDLE) && cmd_valid;
   assign cmd_pop = take;
   assign commit  = (state_ff == ST_EXEC) && (!rsp_valid_ff || pop);
   assign rd_set  = set_of(cmd_item.vpn);

   assign cur_set   = set_of(cmd_ff.vpn);
   assign cur_tag   = TAG_W'(cmd_ff.vpn >> SET_SHIFT);
   assign cur_off   = cmd_ff.offset[PAGE_OFFSET_BITS-1:0];
   assign valid_row = valid_ff[cur_set];

   // way compare and victim search
   always_comb begin
      hit_way  = '0;
      free_way = '0;
      old_way  = '0;
      old_rank = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         rank_cur[w] = valid_row[w] ? rank_rd_ff[w] : '0;
         match[w]    = valid_row[w] && (tag_rd_ff[w] == cur_tag);
      end
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WAY_W'(w);
         end
         if (!valid_row[w]) begin
            free_way = WAY_W'(w);
         end
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (rank_cur[w] > old_rank) begin
            old_rank = rank_cur[w];
            old_way  = WAY_W'(w);
         end
      end
      hit_found  = |match;
      free_found = ~&valid_row;
      victim     = free_found ? free_way : old_way;
   end

   assign is_xlate = (cmd_ff.kind == OP_TRANSLATE);
   assign do_touch = is_xlate && hit_found;
   assign do_fill  = is_xlate && !hit_found && !cmd_ff.walk_fault;
   assign target   = hit_found ? hit_way : victim;
   assign limit    = hit_found ? {1'b0, rank_cur[hit_way]} : LIMIT_FILL;
   assign wr_en    = commit && (do_touch || do_fill);

   // row update
   always_comb begin
      tag_row_in   = tag_rd_ff;
      frame_row_in = frame_rd_ff;
      for (int k = 0; k < NUM_WAYS; k++) begin
         if (WAY_W'(k) == target) begin
            rank_row_in[k] = '0;
         end else if (valid_row[k] && ({1'b0, rank_cur[k]} < limit) &&
                      (rank_cur[k] < RANK_MAX)) begin
            rank_row_in[k] = rank_cur[k] + RANK_W'(1);
         end else begin
            rank_row_in[k] = rank_rd_ff[k];
         end
      end
      if (do_fill) begin
         tag_row_in[victim]   = cur_tag;
         frame_row_in[victim] = cmd_ff.walk_frame;
      end
   end

   // result item
   always_comb begin
      rsp_in = '0;
      case (cmd_ff.kind)
         OP_PEEK: begin
            if (hit_found) begin
               rsp_in.lru_rank = RANK_FIELD_W'({1'b0, rank_cur[hit_way]} +
                                               (RANK_W + 1)'(1));
            end
         end
         OP_TRANSLATE: begin
            if (hit_found) begin
               rsp_in.hit              = 1'b1;
               rsp_in.physical_address = PA_W'({frame_rd_ff[hit_way], cur_off});
            end else if (cmd_ff.walk_fault) begin
               rsp_in.fault = 1'b1;
            end else begin
               rsp_in.physical_address = PA_W'({cmd_ff.walk_frame, cur_off});
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // control next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      valid_in     = valid_ff;
      if (pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         state_in = ST_EXEC;
      end
      if (commit) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         if (cmd_ff.kind == OP_CLEAR) begin
            valid_in = '0;
         end else if (do_fill) begin
            valid_in[cur_set][victim] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff      <= cmd_item;
         tag_rd_ff   <= tag_mem[rd_set];
         frame_rd_ff <= frame_mem[rd_set];
         rank_rd_ff  <= rank_mem[rd_set];
      end
      if (wr_en) begin
         tag_mem[cur_set]   <= tag_row_in;
         frame_mem[cur_set] <= frame_row_in;
         rank_mem[cur_set]  <= rank_row_in;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

### hdl/set_assoc_tlb_lru_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_tlb_lru_unit
// set associative tlb with true lru order: clear, peek rank and translate
// ----------------------------------------------------------------------------
// usage:
//   request side is a queue: an item is taken when push is high and full is
//   low. it carries the operation, the virtual address and the page walk
//   result used when a translate misses.
//   result side is a queue: the oldest result is on rsp_item while empty is
//   low and leaves when pop is high.
//   an item passes through the queue, the engine's command and row
//   registers and the result register before its result is visible.
//   the table engine takes one item at a time: in its idle state it reads
//   a set row from the row memory into registers, and in its exec state it
//   compares all ways and writes the row back before it takes the next item.
//   a two-item queue sits in front of the engine and one result register
//   behind it; when pop stays low the result waits, the engine stalls and
//   requests pile up in the queue until full goes high.
//   reset empties both queues and invalidates every table entry at once.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_tlb_lru_unit #(
   parameter int SET_COUNT        = tlbl_pkg::DEF_SET_COUNT,
   parameter int NUM_WAYS         = tlbl_pkg::DEF_NUM_WAYS,
   parameter int PAGE_OFFSET_BITS = tlbl_pkg::DEF_PAGE_OFFSET_BITS
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   output logic              full,
   input  tlbl_pkg::req_type req_item,
   output logic              empty,
   input  wire               pop,
   output tlbl_pkg::rsp_type rsp_item
);
   import tlbl_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_item;

   tlbl_front #(
      .PAGE_OFFSET_BITS(PAGE_OFFSET_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .cmd_valid(cmd_valid),
      .cmd_item (cmd_item),
      .cmd_pop  (cmd_pop)
   );

   tlbl_back #(
      .SET_COUNT       (SET_COUNT),
      .NUM_WAYS        (NUM_WAYS),
      .PAGE_OFFSET_BITS(PAGE_OFFSET_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd_item (cmd_item),
      .cmd_pop  (cmd_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire
